FILE: rtl/core/b64c_pkg.sv
// Shared types, codes and character mapping functions for the 8-to-12 block codec.
package b64c_pkg;

  // Job kinds handed from the front end to the back end
  localparam logic [1:0] KIND_ENC = 2'd0;  // 12 characters from one 8-byte block
  localparam logic [1:0] KIND_DEC = 2'd1;  // 8 bytes from one 12-character block
  localparam logic [1:0] KIND_ERR = 2'd2;  // single length-error marker

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  // Last index of each job kind
  localparam logic [3:0] ENC_LAST_IDX = 4'd11;
  localparam logic [3:0] DEC_LAST_IDX = 4'd7;

  // Register map
  localparam logic REG_DIRECTION = 1'b0;

  localparam int JOB_DW = 72;

  typedef struct packed {
    logic [JOB_DW-1:0] data;  // encode: 12 six-bit groups; decode: 8 bytes, first in low bits
    logic [1:0]        kind;
    logic              last;
    logic [1:0]        stat;
  } job_t;

  // Map a character code to 0..63, or 64 when outside the alphabet
  function automatic logic [6:0] b64c_char_value(input logic [7:0] c);
    logic [6:0] v;
    if (c == 8'h2e) begin
      v = 7'd0;
    end else if (c == 8'h2f) begin
      v = 7'd1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'd46);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = 7'(c - 8'd85);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      v = 7'(c - 8'd27);
    end else begin
      v = 7'd64;
    end
    return v;
  endfunction

  // Map a six-bit group to its character code
  function automatic logic [7:0] b64c_enc_char(input logic [5:0] g);
    logic [7:0] c;
    if (g == 6'd0) begin
      c = 8'h2e;
    end else if (g == 6'd1) begin
      c = 8'h2f;
    end else if (g < 6'd12) begin
      c = 8'({2'b00, g} + 8'd46);
    end else if (g < 6'd38) begin
      c = 8'({2'b00, g} + 8'd85);
    end else begin
      c = 8'({2'b00, g} + 8'd27);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/b64c_front.sv
// Front end: accepts bytes or characters, assembles blocks and issues jobs.
module b64c_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          dir,
  input  logic          clr,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last_item,
  input  logic          q_full,
  output logic          push,
  output b64c_pkg::job_t push_job
);
  import b64c_pkg::*;

  logic [JOB_DW-1:0] blk_r, blk_nxt, blk_new;
  logic [3:0]        fill_r, fill_nxt;
  logic              bad_r, bad_nxt;
  logic              acc;
  logic [2:0]        enc_k;
  logic [3:0]        dec_k;
  logic [6:0]        cval;
  logic              cbad, bad_any;
  logic [5:0]        cslot;
  logic              enc_done, dec_full;
  logic [31:0]       left_w, right_w;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // Insert the incoming item into the partial block
  always_comb begin
    enc_k   = fill_r[2:0];
    dec_k   = (fill_r > 4'd11) ? 4'd11 : fill_r;
    cval    = b64c_char_value(in_byte);
    cbad    = cval[6];
    cslot   = cbad ? 6'd0 : cval[5:0];
    bad_any = bad_r || cbad;
    blk_new = blk_r;
    if (!dir) begin
      for (int j = 0; j < 8; j++) begin
        if (enc_k == 3'(j)) blk_new[63-8*j -: 8] = in_byte;
      end
    end else begin
      for (int j = 0; j < 12; j++) begin
        if (dec_k == 4'(j)) blk_new[6*j +: 6] = cslot;
      end
    end
  end

  assign enc_done = (enc_k == 3'd7) || in_last_item;
  assign dec_full = (dec_k == 4'd11);
  assign right_w  = blk_new[31:0];
  assign left_w   = dir ? blk_new[67:36] : blk_new[63:32];

  // Build the job for a completed block
  always_comb begin
    push_job.last = in_last_item;
    if (!dir) begin
      push           = acc && enc_done;
      push_job.kind  = KIND_ENC;
      push_job.stat  = ST_OK;
      push_job.data  = {4'b0000, left_w, 4'b0000, right_w};
    end else begin
      push           = acc && (dec_full || in_last_item);
      push_job.kind  = dec_full ? KIND_DEC : KIND_ERR;
      push_job.stat  = !dec_full ? ST_BAD_LEN :
                       ((in_last_item && bad_any) ? ST_BAD_CHAR : ST_OK);
      push_job.data  = {8'h00,
                        right_w[7:0], right_w[15:8], right_w[23:16], right_w[31:24],
                        left_w[7:0], left_w[15:8], left_w[23:16], left_w[31:24]};
    end
  end

  // Advance the block state
  always_comb begin
    blk_nxt  = blk_r;
    fill_nxt = fill_r;
    bad_nxt  = bad_r;
    if (clr) begin
      blk_nxt  = '0;
      fill_nxt = 4'd0;
      bad_nxt  = 1'b0;
    end else if (acc) begin
      if (!dir) begin
        if (enc_done) begin
          blk_nxt  = '0;
          fill_nxt = 4'd0;
        end else begin
          blk_nxt  = blk_new;
          fill_nxt = {1'b0, enc_k} + 4'd1;
        end
      end else begin
        if (dec_full) begin
          blk_nxt  = '0;
          fill_nxt = 4'd0;
          bad_nxt  = in_last_item ? 1'b0 : bad_any;
        end else if (in_last_item) begin
          blk_nxt  = '0;
          fill_nxt = 4'd0;
          bad_nxt  = 1'b0;
        end else begin
          blk_nxt  = blk_new;
          fill_nxt = dec_k + 4'd1;
          bad_nxt  = bad_any;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r  <= '0;
      fill_r <= 4'd0;
      bad_r  <= 1'b0;
    end else begin
      blk_r  <= blk_nxt;
      fill_r <= fill_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

FILE: rtl/core/b64c_queue.sv
// Two-entry job queue between the front end and the back end.
module b64c_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64c_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output b64c_pkg::job_t pop_job
);
  import b64c_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_job   = ent_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_job;
  end

endmodule

FILE: rtl/core/b64c_back.sv
// Back end: serializes one job at a time into result transactions.
module b64c_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  b64c_pkg::job_t q_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic [1:0]     out_status,
  output logic           out_last_out
);
  import b64c_pkg::*;

  logic              busy_r, busy_nxt;
  logic [JOB_DW-1:0] data_r, data_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [3:0]        end_idx;
  logic              at_end, fire;

  // Pick the last index of the current job
  always_comb begin
    unique case (kind_r)
      KIND_ENC: end_idx = ENC_LAST_IDX;
      KIND_DEC: end_idx = DEC_LAST_IDX;
      default:  end_idx = 4'd0;
    endcase
  end

  assign at_end = (idx_r == end_idx);
  assign fire   = busy_r && out_ready;
  assign pop    = q_valid && (!busy_r || (fire && at_end));

  // Drive the result fields from the job registers
  always_comb begin
    unique case (kind_r)
      KIND_ENC: out_byte = b64c_enc_char(data_r[5:0]);
      KIND_DEC: out_byte = data_r[7:0];
      default:  out_byte = 8'h00;
    endcase
  end

  assign out_valid    = busy_r;
  assign out_last_out = last_r && at_end;
  assign out_status   = at_end ? stat_r : ST_OK;

  // Load a new job or advance through the current one
  always_comb begin
    busy_nxt = busy_r;
    data_nxt = data_r;
    kind_nxt = kind_r;
    last_nxt = last_r;
    stat_nxt = stat_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      data_nxt = q_job.data;
      kind_nxt = q_job.kind;
      last_nxt = q_job.last;
      stat_nxt = q_job.stat;
      idx_nxt  = 4'd0;
    end else if (fire) begin
      if (at_end) begin
        busy_nxt = 1'b0;
        idx_nxt  = 4'd0;
      end else begin
        idx_nxt  = idx_r + 4'd1;
        data_nxt = (kind_r == KIND_ENC) ? (data_r >> 6) : (data_r >> 8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
      kind_r <= KIND_ERR;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      kind_r <= kind_nxt;
    end
  end

  // Hold job payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    stat_r <= stat_nxt;
  end

endmodule

FILE: rtl/core/base64_block_codec_8_to_12_top.sv
// A completed block is written into the job queue, then loaded into the back-end job registers that drive results.
// Throughput: one input transaction per cycle while the two-entry job queue has room;
// the back end sends one result per cycle while out_ready is high, giving 12 characters
// per 8-byte block when encoding and 8 bytes per 12-character block when decoding.
// Reset: synchronous active-low rst_n clears direction (encode), the partial block and queue.
module base64_block_codec_8_to_12_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last_out,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import b64c_pkg::*;

  logic dir_r, dir_nxt;
  logic cfg_wr;
  logic clr;
  logic q_full, push, q_valid, pop;
  job_t push_job, q_job;

  // Decode register writes; any write to direction drops the partial block
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign clr        = cfg_wr && (cfg_paddr[2] == REG_DIRECTION);
  assign dir_nxt    = clr ? cfg_pwdata[0] : dir_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_DIRECTION) ? {31'd0, dir_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  b64c_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .dir          (dir_r),
    .clr          (clr),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last_item (in_last_item),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  b64c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  b64c_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_last_out (out_last_out)
  );

endmodule

FILE: tb/tb_base64_block_codec_8_to_12_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 8-to-12 block codec: directed rows, then random messages.
module tb_base64_block_codec_8_to_12_top;
  import b64c_pkg::*;

  localparam logic DIR_ENCODE   = 1'b0;
  localparam logic DIR_DECODE   = 1'b1;
  localparam int   RANDOM_ITEMS = 200;
  localparam int   MAX_SHOWN    = 10;
  localparam int   SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] stat;
    logic       last;
  } codec_res_t;

  typedef struct {
    logic       dir;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] t_data;
    logic [1:0] t_stat;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last_item;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_status;
  logic        out_last_out;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state
  logic        pred_dir  = DIR_ENCODE;
  logic [63:0] pred_blk  = '0;
  logic [3:0]  pred_fill = '0;
  logic        pred_bad  = 1'b0;

  codec_res_t  pending_out[$];
  stim_row_t   directed_rows[$];
  bit          quiet = 1'b0;
  int          errors = 0;
  int          items_sent = 0;
  int          msgs_sent = 0;
  int          results_seen = 0;
  int          status_seen[4] = '{0, 0, 0, 0};

  base64_block_codec_8_to_12_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last_item (in_last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_last_out (out_last_out),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Six-bit group to alphabet character: '.', '/', digits, lower case, upper case
  function automatic logic [7:0] group_char(input logic [5:0] g);
    if (g < 6'd2) return 8'h2e + {2'b00, g};
    if (g < 6'd12) return 8'h30 + {2'b00, g} - 8'd2;
    if (g < 6'd38) return 8'h61 + {2'b00, g} - 8'd12;
    return 8'h41 + {2'b00, g} - 8'd38;
  endfunction

  // Character to group value, 64 when outside the alphabet
  function automatic logic [6:0] char_group(input logic [7:0] c);
    if (c == 8'h2e || c == 8'h2f) return 7'(c - 8'h2e);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd2);
    if (c >= 8'h61 && c <= 8'h7a) return 7'(c - 8'h61 + 8'd12);
    if (c >= 8'h41 && c <= 8'h5a) return 7'(c - 8'h41 + 8'd38);
    return 7'd64;
  endfunction

  function automatic void clear_pred();
    pred_blk  = '0;
    pred_fill = '0;
    pred_bad  = 1'b0;
  endfunction

  // Advance the codec state by one accepted transaction and queue its outputs
  function automatic void codec_predict(input logic [7:0] b, input logic l);
    logic [63:0] sh;
    logic [31:0] word;
    logic [6:0]  v;
    logic [3:0]  k;
    logic [1:0]  st;
    int          n;
    if (pred_dir == DIR_ENCODE) begin
      k = {1'b0, pred_fill[2:0]};
      pred_blk = pred_blk | ({56'd0, b} << (56 - 8 * k));
      pred_fill = k + 4'd1;
      if (pred_fill < 4'd8 && !l) return;
      // Emit right word then left word, low group first
      n = 0;
      for (int h = 0; h < 2; h++) begin
        word = (h == 0) ? pred_blk[31:0] : pred_blk[63:32];
        for (int i = 0; i < 6; i++) begin
          pending_out.push_back('{group_char(word[5:0]), ST_OK, l && n == 11});
          word = word >> 6;
          n++;
        end
      end
      clear_pred();
    end else begin
      v = char_group(b);
      k = (pred_fill > 4'd11) ? 4'd11 : pred_fill;
      if (v > 7'd63) begin
        pred_bad = 1'b1;
        v = 7'd0;
      end
      // Keep only the low 32 bits of each word
      sh = {57'd0, v} << (6 * ((k < 4'd6) ? k : k - 4'd6));
      if (k < 4'd6) pred_blk[31:0] = pred_blk[31:0] | sh[31:0];
      else pred_blk[63:32] = pred_blk[63:32] | sh[31:0];
      pred_fill = k + 4'd1;
      if (pred_fill < 4'd12) begin
        if (!l) return;
        pending_out.push_back('{8'd0, ST_BAD_LEN, 1'b1});
        clear_pred();
        return;
      end
      st = (l && pred_bad) ? ST_BAD_CHAR : ST_OK;
      for (int i = 0; i < 8; i++) begin
        pending_out.push_back('{pred_blk[63 - 8 * i -: 8], (l && i == 7) ? st : ST_OK,
                                l && i == 7});
      end
      pred_blk  = '0;
      pred_fill = '0;
      if (l) pred_bad = 1'b0;
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("%0t ns: mismatch: %s", $time, msg);
  endfunction

  function automatic void add_row(input logic d, input logic [7:0] b, input logic l,
                                  input logic typed, input logic [7:0] t_data,
                                  input logic [1:0] t_stat);
    directed_rows.push_back('{d, b, l, typed, t_data, t_stat});
  endfunction

  // Drive one input transaction after a random gap and predict on acceptance
  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_item <= l;
    do @(posedge clk); while (!in_ready);
    codec_predict(b, l);
    items_sent++;
    if (l) msgs_sent++;
  endtask

  // Drop valid, wait for every expected output, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the direction register, then read it back
  task automatic write_direction(input logic d);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_DIRECTION, 2'b00};
    cfg_pwdata  <= {31'd0, d};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {31'd0, d})
      report_mismatch($sformatf("direction readback expected %0h got %0h", {31'd0, d},
                                cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    pred_dir = d;
    clear_pred();
  endtask

  // Send one message: plain bytes, or mostly well-formed character blocks
  task automatic send_message(input logic d);
    int         len;
    int         kind;
    int         bad_at;
    logic [7:0] c;
    if (d == DIR_ENCODE) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), i == len - 1);
    end else begin
      kind = $urandom_range(0, 9);
      len = 12 * $urandom_range(1, 2);
      if (kind == 7) begin
        do len = $urandom_range(1, 30); while (len % 12 == 0);
      end
      if (kind == 8) len = $urandom_range(1, 30);
      bad_at = (kind == 6) ? $urandom_range(0, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        if (kind == 8) begin
          c = 8'($urandom_range(0, 255));
        end else if (i == bad_at) begin
          do c = 8'($urandom_range(0, 255)); while (char_group(c) < 7'd64);
        end else begin
          c = group_char(6'($urandom_range(0, 63)));
        end
        send_item(c, i == len - 1);
      end
    end
  endtask

  // Output side: random stalls, compare each transaction with the oldest expectation
  initial begin : result_sink
    codec_res_t got;
    codec_res_t want;
    int         stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{out_byte, out_status, out_last_out};
      results_seen++;
      if (got.last) status_seen[got.stat]++;
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte=%02h status=%0d last=%0b",
                                  got.data, got.stat, got.last));
      end else begin
        want = pending_out.pop_front();
        if (got.data !== want.data || got.stat !== want.stat || got.last !== want.last)
          report_mismatch($sformatf({"expected byte=%02h status=%0d last=%0b, ",
                                     "got byte=%02h status=%0d last=%0b"},
                                    want.data, want.stat, want.last,
                                    got.data, got.stat, got.last));
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int        n_directed;
    logic      d;
    in_valid     <= 1'b0;
    in_byte      <= 8'd0;
    in_last_item <= 1'b0;
    out_ready    <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    rst_n        <= 1'b0;

    // Encode a block of all ones: last character is the top two bits of the left word
    for (int i = 0; i < 8; i++)
      add_row(DIR_ENCODE, 8'hff, i == 7, i == 7, 8'h31, ST_OK);
    // Single zero byte: padded block gives all '.'
    add_row(DIR_ENCODE, 8'h00, 1'b1, 1'b1, 8'h2e, ST_OK);
    // Short final block with mixed bits
    add_row(DIR_ENCODE, 8'h80, 1'b0, 1'b0, 8'h00, ST_OK);
    add_row(DIR_ENCODE, 8'h01, 1'b0, 1'b0, 8'h00, ST_OK);
    add_row(DIR_ENCODE, 8'h7f, 1'b1, 1'b0, 8'h00, ST_OK);
    // Zero characters with one outside the alphabet: zero bytes, bad character status
    for (int i = 0; i < 12; i++)
      add_row(DIR_DECODE, (i == 5) ? 8'hff : 8'h2e, i == 11, i == 11, 8'h00, ST_BAD_CHAR);
    // Bad character that also ends an incomplete block: length error wins
    add_row(DIR_DECODE, 8'h00, 1'b1, 1'b1, 8'h00, ST_BAD_LEN);
    n_directed = directed_rows.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed rows
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.dir != pred_dir) begin
        settle();
        write_direction(r.dir);
      end
      send_item(r.data, r.last);
      if (r.typed) pending_out[pending_out.size() - 1] = '{r.t_data, r.t_stat, 1'b1};
    end

    // Random phases: pick a direction, send messages, sometimes leave a block unfinished
    while (items_sent < n_directed + RANDOM_ITEMS) begin
      settle();
      d = 1'($urandom_range(0, 1));
      write_direction(d);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) send_message(d);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 11)) begin
          if (d == DIR_DECODE) send_item(group_char(6'($urandom_range(0, 63))), 1'b0);
          else send_item(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end

    quiet = 1'b0;
    settle();
    $display("Covered %0d input transactions in %0d messages, both directions, %0d outputs %s",
             items_sent, msgs_sent, results_seen, "checked");
    $display("Message endings: %0d ok, %0d bad character, %0d bad length; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_BAD_CHAR], status_seen[ST_BAD_LEN], errors);
    if (errors == 0) begin
      $display("[base64_block_codec_8_to_12_top] OK");
    end else begin
      $display("[base64_block_codec_8_to_12_top] ERROR");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #5_000_000;
    $display("[base64_block_codec_8_to_12_top] ERROR");
    $finish;
  end

endmodule
